@@ design/bpd_pkg.sv @@
// Shared constants and codes for the byte-pair decoder.
`timescale 1ns / 1ps
`default_nettype none

package bpd_pkg;

  // Default size of the pair table.
  localparam int MAX_PAIRS_DEF = 128;

  // Offset between a byte value and a pair index.
  localparam logic [7:0] PAIR_BASE = 8'd128;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_FORWARD    = 3'd2,
    ST_UNDEFINED  = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_REJECTED   = 3'd5
  } status_t;

endpackage

`default_nettype wire

@@ design/byte_pair_decoder.sv @@
// Byte-pair-encoding stream decoder with pair table and expansion stack.
// The result word of an accepted input word is registered in the output register
//   and held there until it is taken.
// Throughput: one input word per cycle while the output register is empty or being taken;
//   every command, including one expansion step, is one table read or one stack push/pop
//   between the state and output registers, with the memory read data prefetched for the next state.
// Reset (rst_n low, synchronous): phase idle, stack empty, error clear, output
//   register empty. Table and stack memories are not cleared; only entries
//   written in the current stream are ever read.
`timescale 1ns / 1ps
`default_nettype none

module byte_pair_decoder #(
  parameter int MAX_PAIRS = bpd_pkg::MAX_PAIRS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] busy_res,
                                       // [11:9] status, [12] finished, [15:13] zero
  output logic             out_tuser   // [0] out_valid
);

  import bpd_pkg::*;

  // Stack holds MAX_PAIRS+1 entries: the top lives in top_r, the rest in memory.
  localparam int STACK_DEPTH = MAX_PAIRS + 1;
  localparam int AW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int LW  = $clog2(MAX_PAIRS + 2);
  localparam int PTW = $clog2(MAX_PAIRS + 1);
  localparam int TFW = $clog2(2 * MAX_PAIRS + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TABLE,
    PH_BODY,
    PH_STOP
  } phase_t;

  // Control state
  phase_t           phase_r, phase_nxt;
  logic [PTW-1:0]   pair_total_r, pair_total_nxt;
  logic [TFW-1:0]   table_fill_r, table_fill_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic [7:0]       top_r, top_nxt;
  status_t          err_r, err_nxt;

  // Output register
  logic             out_tvalid_r;
  logic             res_valid_r;
  logic [7:0]       res_byte_r;
  logic             res_busy_r;
  status_t          res_status_r;
  logic             res_fin_r;

  // Result of the word being accepted
  logic             res_valid;
  logic [7:0]       res_byte;
  status_t          res_status;
  logic             res_fin;

  // Memories: pair table halves and the stack below the top entry
  logic [7:0]       tab_lo_mem [MAX_PAIRS];
  logic [7:0]       tab_hi_mem [MAX_PAIRS];
  logic [7:0]       stk_mem    [MAX_PAIRS];
  logic [7:0]       tab_lo_rd_r, tab_hi_rd_r, stk_rd_r;

  logic             tab_we, tab_hi_sel;
  logic [AW-1:0]    tab_waddr, tab_raddr;
  logic             stk_we;
  logic [AW-1:0]    stk_waddr, stk_raddr;
  logic [7:0]       stk_wdata;

  logic             accept;
  cmd_t             cmd;
  logic [7:0]       din;
  logic [6:0]       tab_idx;
  logic [6:0]       top_idx_nxt;
  logic [TFW-1:0]   fill_inc;
  logic [LW-1:0]    level_m2;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign din       = in_tdata;

  // Index of the pair now being filled, and the fill count after this byte.
  assign tab_idx  = 7'(table_fill_r >> 1);
  assign fill_inc = table_fill_r + TFW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    pair_total_nxt = pair_total_r;
    table_fill_nxt = table_fill_r;
    level_nxt      = level_r;
    top_nxt        = top_r;
    err_nxt        = err_r;
    res_valid      = 1'b0;
    res_byte       = 8'd0;
    res_status     = ST_OK;
    res_fin        = 1'b0;
    tab_we         = 1'b0;
    tab_hi_sel     = table_fill_r[0];
    tab_waddr      = AW'(tab_idx);
    stk_we         = 1'b0;
    stk_waddr      = AW'(level_r - LW'(1));
    stk_wdata      = tab_hi_rd_r;

    if (accept) begin
      if (cmd == CMD_START) begin
        // Restart from scratch, then check the header.
        level_nxt      = '0;
        err_nxt        = ST_OK;
        table_fill_nxt = '0;
        pair_total_nxt = '0;
        if (!din[7] || ({1'b0, din[6:0]} > 8'(MAX_PAIRS))) begin
          phase_nxt = PH_STOP;
          err_nxt   = ST_BAD_HEADER;
        end else begin
          pair_total_nxt = PTW'(din[6:0]);
          phase_nxt      = (din[6:0] == 7'd0) ? PH_BODY : PH_TABLE;
        end
        res_status = err_nxt;
      end else begin
        case (phase_r)
          PH_STOP: begin
            res_status = err_r;
          end
          PH_TABLE: begin
            if (cmd == CMD_DATA) begin
              // A table byte may name a literal or an earlier pair only.
              if ({1'b0, din} >= ({1'b0, PAIR_BASE} + 9'(tab_idx))) begin
                phase_nxt = PH_STOP;
                err_nxt   = ST_FORWARD;
                level_nxt = '0;
              end else begin
                tab_we         = 1'b1;
                table_fill_nxt = fill_inc;
                if (fill_inc >= TFW'({pair_total_r, 1'b0})) begin
                  phase_nxt = PH_BODY;
                end
              end
            end else if (cmd == CMD_END) begin
              phase_nxt = PH_STOP;
              err_nxt   = ST_TRUNCATED;
              level_nxt = '0;
            end
            res_status = err_nxt;
          end
          PH_BODY: begin
            case (cmd)
              CMD_DATA: begin
                if (level_r != '0) begin
                  res_status = ST_REJECTED;
                end else if (!din[7]) begin
                  res_valid = 1'b1;
                  res_byte  = din;
                end else begin
                  // Push a pair code on the empty stack.
                  top_nxt   = din;
                  level_nxt = LW'(1);
                end
              end
              CMD_END: begin
                if (level_r != '0) begin
                  res_status = ST_REJECTED;
                end else begin
                  phase_nxt = PH_STOP;
                  err_nxt   = ST_OK;
                  res_fin   = 1'b1;
                end
              end
              CMD_TICK: begin
                if (level_r != '0) begin
                  if (!top_r[7]) begin
                    // Pop and emit a literal.
                    level_nxt = level_r - LW'(1);
                    top_nxt   = stk_rd_r;
                    res_valid = 1'b1;
                    res_byte  = top_r;
                  end else if ((8'({1'b0, top_r[6:0]}) >= 8'(pair_total_r)) ||
                               (8'({1'b0, top_r[6:0]}) >= 8'(MAX_PAIRS)) ||
                               (level_r >= LW'(STACK_DEPTH))) begin
                    phase_nxt  = PH_STOP;
                    err_nxt    = ST_UNDEFINED;
                    level_nxt  = '0;
                    res_status = ST_UNDEFINED;
                  end else begin
                    // Replace the pair code: second half below, first half on top.
                    stk_we    = 1'b1;
                    top_nxt   = tab_lo_rd_r;
                    level_nxt = level_r + LW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
          default: begin
            // Idle: drop everything but a start.
          end
        endcase
      end
    end
  end

  // Prefetch addresses for the state after this edge.
  assign top_idx_nxt = top_nxt[6:0];
  assign tab_raddr   = ({1'b0, top_idx_nxt} < 8'(MAX_PAIRS)) ? AW'(top_idx_nxt) : '0;
  assign level_m2    = level_nxt - LW'(2);
  assign stk_raddr   = (level_nxt >= LW'(2)) ? AW'(level_m2) : '0;

  // Pair table: one write port per half, registered read at the next top.
  always_ff @(posedge clk) begin
    if (tab_we && !tab_hi_sel) begin
      tab_lo_mem[tab_waddr] <= din;
    end
    if (tab_we && tab_hi_sel) begin
      tab_hi_mem[tab_waddr] <= din;
    end
    tab_lo_rd_r <= tab_lo_mem[tab_raddr];
    tab_hi_rd_r <= tab_hi_mem[tab_raddr];
  end

  // Stack body: registered read of the entry under the next top, with bypass.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_we && (stk_waddr == stk_raddr)) begin
      stk_rd_r <= stk_wdata;
    end else begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // State and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pair_total_r <= '0;
      table_fill_r <= '0;
      level_r      <= '0;
      err_r        <= ST_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pair_total_r <= pair_total_nxt;
      table_fill_r <= table_fill_nxt;
      level_r      <= level_nxt;
      err_r        <= err_nxt;
      if (in_tready) begin
        out_tvalid_r <= accept;
      end
    end
    top_r <= top_nxt;
    if (accept) begin
      res_valid_r  <= res_valid;
      res_byte_r   <= res_byte;
      res_busy_r   <= (level_nxt != '0);
      res_status_r <= res_status;
      res_fin_r    <= res_fin;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = res_valid_r;
  assign out_tdata  = {3'd0, res_fin_r, res_status_r, res_busy_r, res_byte_r};

  // A header with bit 7 clear always stops the stream with a bad-header error.
  a_bad_header: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_START && !din[7]) |=> (phase_r == PH_STOP && err_r == ST_BAD_HEADER))
    else $error("bad header did not stop the decoder");

  // The stack stays empty outside the body phase.
  a_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_BODY) |-> (level_r == '0))
    else $error("stack not empty outside body phase");

  // A literal pop lowers the stack by exactly one.
  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_BODY && cmd == CMD_TICK && level_r != '0 && !top_r[7])
      |=> (level_r == $past(level_r) - LW'(1)))
    else $error("literal pop did not lower the stack by one");

  // A clean end reports no error, no byte and an empty stack.
  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && res_fin_r) |-> (res_status_r == ST_OK && !res_valid_r && !res_busy_r))
    else $error("finished word carries error, byte or busy");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the byte-pair decoder: directed and random streams.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import bpd_pkg::*;

  localparam int STACK_SLOTS  = MAX_PAIRS_DEF + 1;
  localparam int MAX_TICKS    = 400;
  localparam int ITEMS_TARGET = 1850;

  typedef enum logic [1:0] {PH_IDLE, PH_TABLE, PH_BODY, PH_STOP} phase_t;

  typedef struct packed {
    logic       lit_valid;
    logic [7:0] lit;
    logic       busy;
    status_t    status;
    logic       fin;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  // Decoder state as predicted from the accepted words.
  phase_t      dec_phase;
  int          pair_cnt;
  int          fill;
  logic [15:0] pairs [MAX_PAIRS_DEF];
  logic [7:0]  stack [STACK_SLOTS];
  int          depth;
  status_t     err;
  bit          live;

  decode_result_t decoded_q[$];
  int  errs = 0;
  int  effective = 0;
  bit  calm = 1'b0;

  byte_pair_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random unless a calm stretch is running.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 29);
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void stop_on(status_t s);
    err = s;
    dec_phase = PH_STOP;
    depth = 0;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    if (depth < STACK_SLOTS) begin
      stack[depth] = v;
      depth++;
    end
  endfunction

  // Advance the predicted state by one word and return its result word.
  function automatic decode_result_t decode_step(cmd_t c, logic [7:0] b);
    decode_result_t r;
    int idx;
    logic [7:0] top;
    r = '0;
    r.status = ST_OK;
    live = (c == CMD_START) || (dec_phase == PH_TABLE) || (dec_phase == PH_BODY);
    if (c == CMD_START) begin
      depth = 0;
      err = ST_OK;
      fill = 0;
      pair_cnt = 0;
      if (b < 8'd128) begin
        stop_on(ST_BAD_HEADER);
      end else begin
        pair_cnt = int'(b) - 128;
        dec_phase = (pair_cnt == 0) ? PH_BODY : PH_TABLE;
      end
      r.status = err;
    end else if (dec_phase == PH_STOP) begin
      r.status = err;
    end else if (dec_phase == PH_TABLE) begin
      if (c == CMD_DATA) begin
        idx = fill >> 1;
        // a half may name a literal or an earlier pair only
        if (int'(b) >= 128 + idx) begin
          stop_on(ST_FORWARD);
        end else begin
          if (fill[0] == 1'b0) pairs[idx][7:0] = b;
          else pairs[idx][15:8] = b;
          fill++;
          if (fill >= 2 * pair_cnt) dec_phase = PH_BODY;
        end
      end else if (c == CMD_END) begin
        stop_on(ST_TRUNCATED);
      end
      r.status = err;
    end else if (dec_phase == PH_BODY) begin
      if (c == CMD_DATA) begin
        if (depth != 0) begin
          r.status = ST_REJECTED;
        end else if (b < 8'd128) begin
          r.lit_valid = 1'b1;
          r.lit = b;
        end else begin
          push_byte(b);
        end
      end else if (c == CMD_END) begin
        if (depth != 0) begin
          r.status = ST_REJECTED;
        end else begin
          dec_phase = PH_STOP;
          err = ST_OK;
          r.fin = 1'b1;
        end
      end else if (c == CMD_TICK && depth != 0) begin
        top = stack[depth - 1];
        if (top < 8'd128) begin
          depth--;
          r.lit_valid = 1'b1;
          r.lit = top;
        end else begin
          idx = int'(top) - 128;
          if (idx >= pair_cnt || depth >= STACK_SLOTS) begin
            stop_on(ST_UNDEFINED);
            r.status = err;
          end else begin
            // first half ends on top
            depth--;
            push_byte(pairs[idx][15:8]);
            push_byte(pairs[idx][7:0]);
          end
        end
      end
    end
    r.busy = (depth != 0);
    return r;
  endfunction

  task automatic note_error(string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endtask

  // Present one word, hold it until taken, and queue its predicted result.
  task automatic send_word(cmd_t c, logic [7:0] b);
    while (!calm && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoded_q.push_back(decode_step(c, b));
    if (live) effective++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_result
    decode_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        note_error($sformatf("unexpected result word %04h at %0t", out_tdata, $realtime));
      end else begin
        want = decoded_q.pop_front();
        if (out_tuser !== want.lit_valid || out_tdata[7:0] !== want.lit ||
            out_tdata[8] !== want.busy || out_tdata[11:9] !== want.status ||
            out_tdata[12] !== want.fin || out_tdata[15:13] !== 3'd0) begin
          note_error($sformatf(
            "mismatch at %0t: exp valid=%0d byte=%02h busy=%0d status=%0d fin=%0d | got %s",
            $realtime, want.lit_valid, want.lit, want.busy, want.status, want.fin,
            $sformatf("valid=%0d byte=%02h busy=%0d status=%0d fin=%0d pad=%0d",
                      out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[11:9],
                      out_tdata[12], out_tdata[15:13])));
        end
      end
    end
  end

  task automatic test_before_start;
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_END, 8'h00);
  endtask

  // Header with no table, then busy rejection and an undefined pair.
  task automatic test_empty_table;
    send_word(CMD_START, 8'd128);
    send_word(CMD_DATA, 8'd0);
    send_word(CMD_DATA, 8'd127);
    send_word(CMD_TICK, 8'd0);
    send_word(CMD_DATA, 8'd128);
    send_word(CMD_DATA, 8'd5);
    send_word(CMD_END, 8'd0);
    send_word(CMD_TICK, 8'd0);
    send_word(CMD_DATA, 8'd1);
  endtask

  task automatic test_header_and_table;
    send_word(CMD_START, 8'd127);
    send_word(CMD_TICK, 8'd0);
    send_word(CMD_START, 8'd130);
    send_word(CMD_DATA, 8'd65);
    send_word(CMD_DATA, 8'd66);
    send_word(CMD_DATA, 8'd128);
    send_word(CMD_DATA, 8'd129);  // pair names itself
    send_word(CMD_START, 8'd129);
    send_word(CMD_END, 8'd0);
    send_word(CMD_START, 8'd128);
    send_word(CMD_END, 8'd0);
    send_word(CMD_DATA, 8'd42);
  endtask

  // One stream with random content, at times with an undefined pair code or a stray word; chain builds a deep stack.
  task automatic run_stream(bit chain);
    int n;
    int m;
    int ticks;
    logic [7:0] b;
    if (chain) n = $urandom_range(100, 127);
    else if ($urandom_range(99) < 75) n = $urandom_range(0, 8);
    else n = $urandom_range(9, 127);
    send_word(CMD_START, 8'(128 + n));
    for (int i = 0; i < n; i++) begin
      for (int h = 0; h < 2; h++) begin
        if (chain) b = (h == 0 && i > 0) ? 8'(128 + i - 1) : 8'($urandom_range(0, 127));
        else if (i == 0 || $urandom_range(1) == 0) b = 8'($urandom_range(0, 127));
        else b = 8'(128 + $urandom_range(0, i - 1));
        send_word(CMD_DATA, b);
      end
    end
    m = chain ? $urandom_range(1, 2) : $urandom_range(1, 10);
    for (int k = 0; k < m && dec_phase == PH_BODY; k++) begin
      if (n > 0 && (chain || $urandom_range(1) == 1)) begin
        if ($urandom_range(99) < 4) b = 8'(128 + $urandom_range(n, 127));
        else if (chain) b = 8'(128 + n - 1);
        else b = 8'(128 + $urandom_range(0, n - 1));
      end else begin
        b = 8'($urandom_range(0, 127));
      end
      send_word(CMD_DATA, b);
      ticks = 0;
      while (depth != 0 && dec_phase == PH_BODY && ticks < MAX_TICKS) begin
        if ($urandom_range(99) < 3)
          send_word($urandom_range(1) ? CMD_END : CMD_DATA, 8'($urandom));
        send_word(CMD_TICK, 8'($urandom));
        ticks++;
      end
      // drop the stream if expansion runs away; the next start clears it
      if (depth != 0) return;
      if ($urandom_range(99) < 10) send_word(CMD_TICK, 8'($urandom));
    end
    if (dec_phase == PH_BODY) send_word(CMD_END, 8'($urandom));
    if ($urandom_range(99) < 15) send_word(cmd_t'($urandom_range(1, 3)), 8'($urandom));
  endtask

  // Stream cut off in the table, or broken by a forward reference.
  task automatic run_broken;
    int n;
    int cut;
    send_word(CMD_START, 8'(128 + $urandom_range(1, 20)));
    n = pair_cnt;
    cut = $urandom_range(0, 2 * n - 1);
    for (int i = 0; i < cut; i++) send_word(CMD_DATA, 8'($urandom_range(0, 127)));
    case ($urandom_range(2))
      0: send_word(CMD_END, 8'($urandom));
      1: send_word(CMD_DATA, 8'(128 + cut / 2 + $urandom_range(0, 127 - cut / 2)));
      default: begin
        send_word(CMD_TICK, 8'($urandom));
        send_word(CMD_END, 8'($urandom));
      end
    endcase
    repeat ($urandom_range(0, 3)) send_word(cmd_t'($urandom_range(1, 3)), 8'($urandom));
  endtask

  task automatic run_noise;
    repeat ($urandom_range(1, 12)) send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic test_no_idle;
    calm = 1'b1;
    repeat (2) run_stream(1'b0);
    run_stream(1'b1);
    calm = 1'b0;
  endtask

  task automatic test_random;
    int pick;
    while (effective < ITEMS_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 75) run_stream(1'b0);
      else if (pick < 80) run_stream(1'b1);
      else if (pick < 90) run_broken;
      else run_noise;
    end
  endtask

  initial begin
    dec_phase = PH_IDLE;
    pair_cnt = 0;
    fill = 0;
    depth = 0;
    err = ST_OK;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_before_start;
    test_empty_table;
    test_header_and_table;
    test_no_idle;
    test_random;
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/bpd_pkg.sv
design/byte_pair_decoder.sv
test/tb_top.sv
